// File: design/line_editor_with_echo_defines.svh
// ---------------------------------------------------------------------------
// Line editor assertion macros
// Shared concurrent assertion helpers; compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef LINE_EDITOR_WITH_ECHO_DEFINES_SVH
`define LINE_EDITOR_WITH_ECHO_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every clock edge outside reset
`define LNED_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define LNED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// cons must hold in the same cycle as ante
`define LNED_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define LNED_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define LNED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define LNED_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: design/lned_pkg.sv
// ---------------------------------------------------------------------------
// Line editor package
// Payload structs, result descriptors and character constants.
// ---------------------------------------------------------------------------
package lned_pkg;

    localparam int BUF_DEPTH     = 256;
    localparam int ADDR_W        = $clog2(BUF_DEPTH);
    localparam int MAX_LEN_W     = 9;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(256);

    // opcodes
    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // characters
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       line_done;
        logic [7:0] line_length;
        logic       overflowed;
        logic [7:0] read_data;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        RES_ECHO,
        RES_ERASE,
        RES_END_ECHO,
        RES_END_QUIET,
        RES_READ
    } t_res_kind;

    // what the output sequencer expands into one or three results
    typedef struct packed {
        t_res_kind  kind;
        logic [7:0] echo_byte;
        logic [7:0] line_length;
        logic       overflowed;
        logic       rd_hit;
    } t_res_desc;

    // one access to the line store per item
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// File: design/line_editor_with_echo.sv
// ---------------------------------------------------------------------------
// Line editor with echo
// Builds one edited console line in a RAM, echoes input, reports line ends
// and reads stored characters back by index.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall| o_out_data (t_out_item)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_data (max_length)
//
//  An item is taken every cycle while the result register is free or is
//  handing over its final result; a new item may enter the cycle its
//  predecessor's last result transfers.
//  Echo, line end and read items give one result, from the result register;
//  erase gives three, so the result register holds the input off until its last one transfers.
//  Read data comes from the RAM's registered port, loaded when the item is taken.
//  Synchronous reset clears counters and flags; the line RAM is not cleared.
//  A stall on the output only holds the result register; state already moved.
// ---------------------------------------------------------------------------
`include "line_editor_with_echo_defines.svh"

module line_editor_with_echo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_in_valid,
    input  lned_pkg::t_in_item                 i_in_data,
    output logic                               o_in_stall,
    // results
    output logic                               o_out_valid,
    output lned_pkg::t_out_item                o_out_data,
    input  logic                               i_out_stall,
    // max_length register write
    input  logic                               i_cfg_valid,
    input  logic [lned_pkg::MAX_LEN_W-1:0]     i_cfg_data,
    output logic                               o_cfg_ready
);

    logic                in_xfer;
    logic                busy;
    lned_pkg::t_mem_req  mem_req;
    logic [7:0]          rdata;
    logic                desc_valid;
    lned_pkg::t_res_desc desc;

    // the user is to issue writes only while idle (not enforced here); the port never pushes back
    assign o_cfg_ready = 1'b1;

    // the input waits only for the result register
    assign o_in_stall = busy;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // edit state: count, discard phase, overflow, last finished line
    lned_edit_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (in_xfer),
        .i_item       (i_in_data),
        .o_mem_req    (mem_req),
        .o_desc_valid (desc_valid),
        .o_desc       (desc)
    );

    // character store; a write and a later read never share an edge,
    // so a read always sees the previous item's write
    lned_line_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // result register and erase expansion
    lned_out_seq u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (desc_valid),
        .i_desc  (desc),
        .i_rdata (rdata),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .o_busy  (busy)
    );

    // no new item while an erase sequence still has results to give
    `LNED_ASSERT_ALWAYS(a_no_take_mid_seq, i_clk, i_rst_n, !(in_xfer && o_out_valid && !o_out_data.last), "item taken before last result")

    // a non-final result is always followed by another one
    `LNED_ASSERT_NEXT(a_seq_continues, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out_data.last, o_out_valid, "result sequence broken")

    // an echoed line end always echoes newline
    `LNED_ASSERT_SAME(a_end_echo_lf, i_clk, i_rst_n, o_out_valid && o_out_data.line_done && o_out_data.echo_valid, o_out_data.echo_byte == lned_pkg::CH_LF, "line end echo not newline")

endmodule

// File: design/lned_line_ram.sv
// ---------------------------------------------------------------------------
// Line store RAM
// One write and one registered read per cycle; no reset of contents.
// ---------------------------------------------------------------------------
module lned_line_ram (
    input  logic               i_clk,
    input  lned_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);

    logic [7:0] mem [lned_pkg::BUF_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lned_edit_ctrl.sv
// ---------------------------------------------------------------------------
// Line edit control
// Tracks count, discard and overflow; issues store accesses and descriptors.
// ---------------------------------------------------------------------------
module lned_edit_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lned_pkg::MAX_LEN_W-1:0]      i_cfg_data,
    input  logic                                i_accept,
    input  lned_pkg::t_in_item                  i_item,
    output lned_pkg::t_mem_req                  o_mem_req,
    output logic                                o_desc_valid,
    output lned_pkg::t_res_desc                 o_desc
);

    logic [lned_pkg::MAX_LEN_W-1:0] r_max_len;
    logic [lned_pkg::ADDR_W-1:0]    r_count, n_count;
    logic                           r_discard, n_discard;
    logic                           r_ovf, n_ovf;
    logic [7:0]                     r_fin_len, n_fin_len;
    logic                           r_fin_ovf, n_fin_ovf;

    logic [lned_pkg::ADDR_W-1:0]    cap;
    logic [7:0]                     rx;
    logic                           disc_now;
    logic                           finish;

    // capacity = clamp(max_length, 1, depth) - 1
    always_comb begin
        if (r_max_len == '0) begin
            cap = '0;
        end else if (r_max_len > lned_pkg::MAX_LEN_W'(lned_pkg::BUF_DEPTH)) begin
            cap = lned_pkg::ADDR_W'(lned_pkg::BUF_DEPTH - 1);
        end else begin
            cap = lned_pkg::ADDR_W'(r_max_len - 1'b1);
        end
    end

    assign rx       = (i_item.rx_byte == lned_pkg::CH_CR) ? lned_pkg::CH_LF : i_item.rx_byte;
    assign disc_now = r_discard || (r_count >= cap);

    always_comb begin
        n_count      = r_count;
        n_discard    = r_discard;
        n_ovf        = r_ovf;
        n_fin_len    = r_fin_len;
        n_fin_ovf    = r_fin_ovf;
        o_mem_req    = '0;
        o_desc_valid = 1'b0;
        o_desc       = '{kind: lned_pkg::RES_ECHO, default: '0};
        finish       = 1'b0;

        if (i_accept) begin
            unique case (i_item.opcode)
                lned_pkg::OP_RX: begin
                    if (rx == lned_pkg::CH_LF) begin
                        finish       = 1'b1;
                        o_desc_valid = 1'b1;
                        o_desc.kind  = lned_pkg::RES_END_ECHO;
                    end else if (disc_now) begin
                        n_discard = 1'b1;
                        n_ovf     = 1'b1;
                    end else if (rx == lned_pkg::CH_DEL || rx == lned_pkg::CH_BS) begin
                        if (r_count != '0) begin
                            n_count      = r_count - 1'b1;
                            o_desc_valid = 1'b1;
                            o_desc.kind  = lned_pkg::RES_ERASE;
                        end
                    end else begin
                        o_mem_req.we     = 1'b1;
                        o_mem_req.waddr  = r_count;
                        o_mem_req.wdata  = rx;
                        n_count          = r_count + 1'b1;
                        n_discard        = ({1'b0, r_count} + 1'b1) >= {1'b0, cap};
                        o_desc_valid     = 1'b1;
                        o_desc.kind      = lned_pkg::RES_ECHO;
                        o_desc.echo_byte = rx;
                    end
                end
                lned_pkg::OP_CLOSE: begin
                    finish       = 1'b1;
                    o_desc_valid = 1'b1;
                    o_desc.kind  = lned_pkg::RES_END_QUIET;
                end
                lned_pkg::OP_READ: begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = i_item.read_index;
                    o_desc_valid    = 1'b1;
                    o_desc.kind     = lned_pkg::RES_READ;
                    o_desc.rd_hit   = i_item.read_index < r_fin_len;
                end
                default: begin
                end
            endcase
        end

        if (finish) begin
            // truncation: terminator lands on the last slot of an overflowed line
            o_mem_req.we       = r_ovf && (r_count != '0) && (cap != '0);
            o_mem_req.waddr    = cap - 1'b1;
            o_mem_req.wdata    = '0;
            o_desc.line_length = r_count;
            o_desc.overflowed  = r_ovf;
            n_fin_len          = r_count;
            n_fin_ovf          = r_ovf;
            n_count            = '0;
            n_discard          = 1'b0;
            n_ovf              = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lned_pkg::MAX_LEN_RESET;
            r_count   <= '0;
            r_discard <= 1'b0;
            r_ovf     <= 1'b0;
            r_fin_len <= '0;
            r_fin_ovf <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            r_count   <= n_count;
            r_discard <= n_discard;
            r_ovf     <= n_ovf;
            r_fin_len <= n_fin_len;
            r_fin_ovf <= n_fin_ovf;
        end
    end

endmodule

// File: design/lned_out_seq.sv
// ---------------------------------------------------------------------------
// Result sequencer
// Holds one descriptor and expands it into one or three result transfers.
// ---------------------------------------------------------------------------
module lned_out_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lned_pkg::t_res_desc i_desc,
    input  logic [7:0]          i_rdata,
    input  logic                i_stall,
    output logic                o_valid,
    output lned_pkg::t_out_item o_item,
    output logic                o_busy
);

    logic                r_valid;
    logic [1:0]          r_step;
    lned_pkg::t_res_desc r_desc;
    logic                fire;

    always_comb begin
        o_item = '0;
        unique case (r_desc.kind)
            lned_pkg::RES_ECHO: begin
                o_item.echo_valid = 1'b1;
                o_item.echo_byte  = r_desc.echo_byte;
                o_item.last       = 1'b1;
            end
            lned_pkg::RES_ERASE: begin
                // backspace, space, backspace
                o_item.echo_valid = 1'b1;
                o_item.echo_byte  = (r_step == 2'd1) ? lned_pkg::CH_SP : lned_pkg::CH_BS;
                o_item.last       = (r_step == 2'd2);
            end
            lned_pkg::RES_END_ECHO: begin
                o_item.echo_valid  = 1'b1;
                o_item.echo_byte   = lned_pkg::CH_LF;
                o_item.line_done   = 1'b1;
                o_item.line_length = r_desc.line_length;
                o_item.overflowed  = r_desc.overflowed;
                o_item.last        = 1'b1;
            end
            lned_pkg::RES_END_QUIET: begin
                o_item.line_done   = 1'b1;
                o_item.line_length = r_desc.line_length;
                o_item.overflowed  = r_desc.overflowed;
                o_item.last        = 1'b1;
            end
            lned_pkg::RES_READ: begin
                o_item.read_data = r_desc.rd_hit ? i_rdata : 8'h00;
                o_item.last      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_valid;
    assign fire    = r_valid && !i_stall;
    assign o_busy  = r_valid && !(fire && o_item.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_step  <= '0;
        end else if (fire) begin
            if (o_item.last) begin
                r_valid <= 1'b0;
            end
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
    end

endmodule

// File: test/line_editor_with_echo_checker.sv
// ---------------------------------------------------------------------------
// Line editor result checker
// Watches the input, result and max_length channels of the line editor.
// Keeps its own copy of the line state, works out the results of every
// accepted transfer and compares each result transfer, field by field,
// with the oldest one still owed.
// ---------------------------------------------------------------------------
module line_editor_with_echo_checker
    import lned_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_data,
    input  logic                 i_in_stall,
    input  logic                 i_out_valid,
    input  t_out_item            i_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_valid,
    input  logic [MAX_LEN_W-1:0] i_cfg_data,
    input  logic                 i_cfg_ready,
    output int                   o_fail_count,
    output int                   o_pending
);

    // shadow line state
    logic [7:0]           line_chars [BUF_DEPTH];
    int unsigned          chars_held;
    logic                 discarding;
    logic                 line_overflow;
    logic [7:0]           done_length;
    logic                 done_overflow;
    logic [MAX_LEN_W-1:0] max_length;

    t_out_item            owed_results [$];
    t_out_item            got;
    t_out_item            want;

    // buffer size after clamping to 1..BUF_DEPTH
    function automatic int unsigned buffer_size();
        int unsigned e;
        e = 32'(max_length);
        if (e < 1) e = 1;
        if (e > BUF_DEPTH) e = BUF_DEPTH;
        if (e > 256) e = 256;
        return e;
    endfunction

    function automatic t_out_item make_result(logic ev, logic [7:0] eb, logic done,
                                              logic [7:0] len, logic ovf, logic [7:0] rd);
        t_out_item r;
        r.echo_valid  = ev;
        r.echo_byte   = eb;
        r.line_done   = done;
        r.line_length = len;
        r.overflowed  = ovf;
        r.read_data   = rd;
        r.last        = 1'b0;
        return r;
    endfunction

    // line end: truncate an overflowed line, latch length, start a new line
    function automatic void end_line();
        int unsigned e;
        e = buffer_size();
        if (line_overflow && chars_held > 0 && e >= 2)
            line_chars[(e - 2) % BUF_DEPTH] = 8'h00;
        done_length   = 8'(chars_held);
        done_overflow = line_overflow;
        chars_held    = 0;
        discarding    = 1'b0;
        line_overflow = 1'b0;
    endfunction

    function automatic void edit_line(input t_in_item item);
        t_out_item   batch [$];
        t_out_item   r;
        logic [7:0]  ch;
        int unsigned cap;
        ch  = item.rx_byte;
        cap = buffer_size() - 1;
        case (item.opcode)
            OP_RX: begin
                if (ch == CH_CR) ch = CH_LF;
                if (!discarding && chars_held >= cap) discarding = 1'b1;
                if (ch == CH_LF) begin
                    end_line();
                    batch.push_back(make_result(1'b1, CH_LF, 1'b1, done_length,
                                                done_overflow, 8'h00));
                end else if (discarding) begin
                    line_overflow = 1'b1;
                end else if (ch == CH_DEL || ch == CH_BS) begin
                    // erase on an empty line is silent
                    if (chars_held > 0) begin
                        chars_held--;
                        batch.push_back(make_result(1'b1, CH_BS, 1'b0, 8'h00, 1'b0, 8'h00));
                        batch.push_back(make_result(1'b1, CH_SP, 1'b0, 8'h00, 1'b0, 8'h00));
                        batch.push_back(make_result(1'b1, CH_BS, 1'b0, 8'h00, 1'b0, 8'h00));
                    end
                end else begin
                    line_chars[chars_held % BUF_DEPTH] = ch;
                    chars_held++;
                    if (chars_held >= cap) discarding = 1'b1;
                    batch.push_back(make_result(1'b1, ch, 1'b0, 8'h00, 1'b0, 8'h00));
                end
            end
            OP_CLOSE: begin
                end_line();
                batch.push_back(make_result(1'b0, 8'h00, 1'b1, done_length,
                                            done_overflow, 8'h00));
            end
            OP_READ: begin
                batch.push_back(make_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b0,
                    (item.read_index < done_length) ? line_chars[item.read_index] : 8'h00));
            end
            default: ;
        endcase
        for (int i = 0; i < batch.size(); i++) begin
            r = batch[i];
            r.last = (i == batch.size() - 1);
            owed_results.push_back(r);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] exp_val,
                                          input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chars_held    = 0;
            discarding    = 1'b0;
            line_overflow = 1'b0;
            done_length   = 8'h00;
            done_overflow = 1'b0;
            max_length    = MAX_LEN_RESET;
            o_fail_count  = 0;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                max_length = i_cfg_data;
            // results belong to earlier transfers, so check them first
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (owed_results.size() == 0) begin
                    $error("result transfer with nothing owed: %0h", got);
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    compare_field("echo_valid",  8'(want.echo_valid), 8'(got.echo_valid));
                    compare_field("echo_byte",   want.echo_byte,      got.echo_byte);
                    compare_field("line_done",   8'(want.line_done),  8'(got.line_done));
                    compare_field("line_length", want.line_length,    got.line_length);
                    compare_field("overflowed",  8'(want.overflowed), 8'(got.overflowed));
                    compare_field("read_data",   want.read_data,      got.read_data);
                    compare_field("last",        8'(want.last),       8'(got.last));
                end
            end
            if (i_in_valid && !i_in_stall)
                edit_line(i_in_data);
        end
        o_pending <= owed_results.size();
    end

endmodule

// File: test/tb_line_editor_with_echo.sv
// ---------------------------------------------------------------------------
// Line editor testbench
// Drives console bytes, line closes and read-backs into the line editor
// under several max_length settings, stalls the result side on its own
// pattern and lets the checker predict and compare every result.
// ---------------------------------------------------------------------------
module tb_line_editor_with_echo;
    import lned_pkg::*;

    // opcode the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_data   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_item            out_data;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [MAX_LEN_W-1:0] cfg_data  = '0;
    logic                 cfg_ready;

    int fail_count;
    int pending;

    // sender pacing
    int items_offered = 0;
    int burst_left    = 0;
    int gapless_left  = 0;

    // receiver long hold-off: stimulus bumps the request count
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int stall_mode    = 0;
    int mode_left     = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    line_editor_with_echo dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    line_editor_with_echo_checker echo_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_data    (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_data),
        .i_out_stall  (out_stall),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_data   (cfg_data),
        .i_cfg_ready  (cfg_ready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side. A pending hold-off request wins; otherwise the stall
    // pattern switches between free-running, half-stalled and mostly
    // stalled stretches of random length.
    always @(posedge clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(10, 80);
            end
            mode_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Mostly printable text, sometimes any byte (control codes included).
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 99) < 80)
            return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    // One input transfer. Between bursts the sender drops valid for a
    // random gap; during a squeeze it offers back to back.
    task automatic send(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] idx);
        t_in_item item;
        item.opcode     = op;
        item.rx_byte    = ch;
        item.read_index = idx;
        if (gapless_left > 0) begin
            gapless_left--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        if (op != OP_UNUSED) items_offered++;
    endtask

    // Wait until every owed result has arrived, then keep waiting for
    // transfers that leave no result behind.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [MAX_LEN_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Lines of random length and content, each ended by newline, carriage
    // return or close, followed by a few read-backs and now and then a
    // stray transfer of any opcode.
    task automatic run_phase(input logic [MAX_LEN_W-1:0] setting, input int quota,
                             input int min_line, input int max_line,
                             input int erase_pct, input bit squeeze);
        int first_item;
        int len;
        int n_reads;
        write_max_length(setting);
        if (squeeze) begin
            // long receiver hold-off while the sender keeps pushing
            hold_requests++;
            gapless_left = 40;
        end
        first_item = items_offered;
        while (items_offered - first_item < quota) begin
            len = $urandom_range(min_line, max_line);
            repeat (len) begin
                if ($urandom_range(0, 99) < erase_pct)
                    send(OP_RX, $urandom_range(0, 1) ? CH_BS : CH_DEL, 8'($urandom));
                else
                    send(OP_RX, pick_char(), 8'($urandom));
            end
            case ($urandom_range(0, 9))
                0, 1:    send(OP_CLOSE, 8'($urandom), 8'($urandom));
                2, 3:    send(OP_RX, CH_CR, 8'($urandom));
                default: send(OP_RX, CH_LF, 8'($urandom));
            endcase
            n_reads = $urandom_range(0, 3);
            repeat (n_reads) begin
                if ($urandom_range(0, 1))
                    send(OP_READ, 8'($urandom),
                         8'($urandom_range(0, (len < 255) ? len + 1 : 255)));
                else
                    send(OP_READ, 8'($urandom), 8'($urandom));
            end
            if ($urandom_range(0, 5) == 0)
                send(2'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset size 256 ---
        send(OP_READ, 8'h00, 8'h00);      // nothing finished yet, reads 0
        send(OP_RX, CH_BS, 8'h00);        // erase on empty line: silent
        send(OP_RX, 8'h61, 8'h00);
        send(OP_RX, 8'hFF, 8'hFF);
        send(OP_RX, 8'h00, 8'h00);
        send(OP_RX, CH_DEL, 8'h00);       // erase echo triple
        send(OP_RX, CH_CR, 8'h00);        // CR ends the line like LF
        send(OP_READ, 8'h00, 8'h00);
        send(OP_READ, 8'h00, 8'h01);
        send(OP_READ, 8'h00, 8'h02);      // at line end
        send(OP_READ, 8'h00, 8'hFF);
        send(OP_UNUSED, 8'hFF, 8'hFF);    // ignored
        send(OP_RX, 8'h78, 8'h00);
        send(OP_CLOSE, 8'h00, 8'h00);     // close without echo
        send(OP_CLOSE, 8'h00, 8'h00);     // close on empty line

        // zero capacity: first byte already overflows
        write_max_length(9'd1);
        send(OP_RX, 8'h71, 8'h00);
        send(OP_RX, CH_LF, 8'h00);

        // capacity two: discard phase, dropped erase, truncation on line end
        write_max_length(9'd3);
        send(OP_RX, 8'h61, 8'h00);
        send(OP_RX, 8'h62, 8'h00);
        send(OP_RX, 8'h63, 8'h00);
        send(OP_RX, CH_BS, 8'h00);
        send(OP_RX, CH_LF, 8'h00);
        send(OP_READ, 8'h00, 8'h00);
        send(OP_READ, 8'h00, 8'h01);      // truncated to 0

        // --- random phases ---
        run_phase(9'd256, 1, 255, 258, 0, 1'b0);   // full line, overflow at 255
        run_phase(9'd2,   12, 0, 4,  15, 1'b0);
        run_phase(9'd1,   10, 0, 3,  15, 1'b0);
        run_phase(9'd5,   16, 0, 7,  15, 1'b1);
        run_phase(9'd511, 16, 0, 12, 15, 1'b0);
        run_phase(9'd300, 10, 0, 12, 15, 1'b0);
        run_phase(9'd9,   16, 0, 11, 15, 1'b0);
        run_phase(9'd0,   10, 0, 3,  15, 1'b0);
        run_phase(9'd17,  16, 0, 19, 15, 1'b0);
        run_phase(9'd256, 12, 0, 12, 15, 1'b0);

        drain();
        if (fail_count == 0)
            $display("line_editor_with_echo: match");
        else
            $display("line_editor_with_echo: mismatch");
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("line_editor_with_echo: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/lned_pkg.sv
design/lned_line_ram.sv
design/lned_edit_ctrl.sv
design/lned_out_seq.sv
design/line_editor_with_echo.sv
test/line_editor_with_echo_checker.sv
test/tb_line_editor_with_echo.sv
